FILE: design/khist_pkg.sv
// Shared types, constants and field layout for the Kasiski factor histogram.
package khist_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_FACTOR_DEF     = 32;
  localparam int DISTANCE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF    = 16;

  // Register and result field widths
  localparam int CFG_WIDTH  = 6;
  localparam int FACTOR_W   = 6;
  localparam int COUNT_W    = 16;
  localparam int SCORE_W    = 17;
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [CFG_WIDTH-1:0] MIN_FACTOR_RESET = 6'd2;
  localparam logic [CFG_WIDTH-1:0] MAX_FACTOR_RESET = 6'd20;

  // Remainder unit consumes this many dividend bits per cycle
  localparam int REM_BITS_PER_CYCLE = 8;

  // Result tdata layout, lowest field first
  localparam int FACTOR_LSB   = 0;
  localparam int COUNT_LSB    = FACTOR_LSB + FACTOR_W;
  localparam int SCORE_LSB    = COUNT_LSB + COUNT_W;
  localparam int TDATA_USED_W = SCORE_LSB + SCORE_W;
  localparam int M_TDATA_W    = ((TDATA_USED_W + 7) / 8) * 8;

  // Score of one full unit (1.0)
  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  // Register index, taken from paddr bit 2
  typedef enum logic {
    REG_MIN_FACTOR = 1'b0,
    REG_MAX_FACTOR = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_DIV,
    ST_ADD_UPD,
    ST_RPT_SCAN,
    ST_RPT_WAIT,
    ST_RPT_DIV,
    ST_RPT_EMIT,
    ST_RPT_EMPTY
  } state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

FILE: design/khist_rem.sv
// Multi-cycle remainder unit: dividend mod a narrow divisor, several bits per cycle.
module khist_rem #(
  parameter int DW = 16,
  parameter int VW = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DW-1:0]          dividend,
  input  logic [VW-1:0]          divisor,
  output khist_pkg::rem_status_t status
);
  import khist_pkg::*;

  localparam int STEP   = REM_BITS_PER_CYCLE;
  localparam int ROUNDS = (DW + STEP - 1) / STEP;
  localparam int PW     = ROUNDS * STEP;
  localparam int RCW    = $clog2(ROUNDS + 1);

  logic [PW-1:0]  shreg;
  logic [VW-1:0]  rem;
  logic [VW-1:0]  divr;
  logic [RCW-1:0] rounds_left;
  logic           busy;
  logic           done;
  logic [VW-1:0]  rem_next;

  // Restoring steps on the narrow remainder, most significant dividend bit first
  always_comb begin
    logic [VW:0] r;
    logic [VW:0] t;
    r = {1'b0, rem};
    t = '0;
    for (int k = 0; k < STEP; k++) begin
      t = {r[VW-1:0], shreg[PW-1-k]};
      r = (t >= {1'b0, divr}) ? t - {1'b0, divr} : t;
    end
    rem_next = r[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (rounds_left == RCW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (rounds_left == RCW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg       <= PW'(dividend);
      rem         <= '0;
      divr        <= divisor;
      rounds_left <= RCW'(ROUNDS);
    end else if (busy) begin
      shreg       <= shreg << STEP;
      rem         <= rem_next;
      rounds_left <= rounds_left - RCW'(1);
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

FILE: design/khist_frac.sv
// Bit-serial fraction divider: floor(num * 2^16 / den) for num not above den.
module khist_frac #(
  parameter int CW = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [CW-1:0]                 num,
  input  logic [CW-1:0]                 den,
  output logic                          done,
  output logic [khist_pkg::SCORE_W-1:0] quot
);
  import khist_pkg::*;

  localparam int QCW = $clog2(SCORE_W + 1);

  logic [CW-1:0]  r;
  logic [CW-1:0]  dreg;
  logic [QCW-1:0] bits_left;
  logic           first;
  logic           busy;
  logic [CW:0]    trial;
  logic           ge;

  // First step compares without a shift, as num never exceeds den
  assign trial = first ? {1'b0, r} : {r, 1'b0};
  assign ge    = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bits_left == QCW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bits_left == QCW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r         <= num;
      dreg      <= den;
      quot      <= '0;
      first     <= 1'b1;
      bits_left <= QCW'(SCORE_W);
    end else if (busy) begin
      r         <= ge ? CW'(trial - {1'b0, dreg}) : CW'(trial);
      quot      <= {quot[SCORE_W-2:0], ge};
      first     <= 1'b0;
      bits_left <= bits_left - QCW'(1);
    end
  end

endmodule

FILE: design/kasiski_factor_histogram_top.sv
// Top level of the Kasiski factor histogram: sequencer, count memory and APB registers.
//
// Each request on the slave stream is either an add (tuser 0) carrying a repeat distance,
// or a report (tuser 1). An add tests every factor from max(min_factor,1) up to
// min(max_factor, MAX_FACTOR, distance) and bumps the saturating count of each one that
// divides the distance; it produces no result. Each tested factor is read as the remainder
// unit starts, waits through the remainder rounds until the unit's registered done flag,
// and is written back when it divides the distance; an empty range is accepted and dropped.
// A report walks the count memory in ascending factor order, stepping past factors with a
// zero count; each nonzero factor is read, then starts the 17-step bit-serial score divider
// and waits for its registered done flag, then is emitted, which back-pressure on the master
// stream can hold. It sends one result per nonzero count with tlast on the final one, or a
// single result with tuser 0 when nothing was counted, and leaves every count and the
// largest count cleared. Counts are held in a memory with a registered read; a valid flag
// per entry, cleared by reset and by the report, marks entries that hold a count, so no
// clearing pass is needed.
// Registers: min_factor at byte address 0, max_factor at 4 (6 bits each); write them only
// while the block is idle.
module kasiski_factor_histogram_top #(
  parameter int MAX_FACTOR     = khist_pkg::MAX_FACTOR_DEF,
  parameter int DISTANCE_WIDTH = khist_pkg::DISTANCE_WIDTH_DEF,
  parameter int COUNT_WIDTH    = khist_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Slave stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((DISTANCE_WIDTH+7)/8)*8-1:0]     s_tdata,  // [DISTANCE_WIDTH-1:0] distance
  input  logic                                    s_tuser,  // [0] operation
  // Master stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [khist_pkg::M_TDATA_W-1:0]         m_tdata,  // [5:0] factor, [21:6] count,
                                                            // [38:22] score
  output logic                                    m_tuser,  // [0] valid_res
  output logic                                    m_tlast,  // last result of a report
  // APB register port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [khist_pkg::PADDR_W-1:0]           paddr,
  input  logic [khist_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [khist_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                    pready
);
  import khist_pkg::*;

  localparam int DW   = DISTANCE_WIDTH;
  localparam int CW   = COUNT_WIDTH;
  localparam int FW   = $clog2(MAX_FACTOR + 1);   // holds a factor up to MAX_FACTOR
  localparam int AW   = $clog2(MAX_FACTOR);       // count memory address
  localparam int CMPW = (FW > CFG_WIDTH) ? FW : CFG_WIDTH;
  localparam int EXTW = (DW > CMPW) ? DW : CMPW;  // width for the range compare

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  state_t state, state_next;

  // Configuration registers
  logic [CFG_WIDTH-1:0] min_factor;
  logic [CFG_WIDTH-1:0] max_factor;

  // Count memory and per-entry valid flags
  logic [CW-1:0]         cnt_mem [MAX_FACTOR];
  logic [MAX_FACTOR-1:0] cnt_valid;
  logic [CW-1:0]         rd_data;
  logic                  rd_valid;
  logic [CW-1:0]         largest;

  // Sequencer registers
  logic [DW-1:0] distance;
  logic [FW-1:0] f;
  logic [FW-1:0] hi;
  logic [AW-1:0] idx;

  // Control from the output decode
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic          rem_start;
  logic          frac_start;
  logic          out_load;

  logic          s_acc;
  logic          cfg_wr;
  logic          out_free;
  logic [AW-1:0] f_addr;

  // Range of an incoming add request
  logic [CFG_WIDTH-1:0] lo6;
  logic [EXTW-1:0]      lo_ext;
  logic [EXTW-1:0]      hi_a;
  logic [EXTW-1:0]      hi_b;
  logic                 range_ok;

  // Read-modify-write values
  logic [CW-1:0] cur_cnt;
  logic [CW-1:0] inc_cnt;

  // Report helpers
  logic [MAX_FACTOR-1:0] valid_above;
  logic                  last_here;

  // Submodule results
  rem_status_t          rem_status;
  logic                 frac_done;
  logic [SCORE_W-1:0]   frac_quot;

  // Result register payload
  logic [FACTOR_W-1:0]  out_factor;
  logic [COUNT_W-1:0]   out_count;
  logic [SCORE_W-1:0]   out_score;
  logic                 out_valid_res;
  logic                 out_last;

  assign s_acc    = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign f_addr   = AW'(f - FW'(1));

  // Clamp the tested range: factor zero reads as one, top bounded by storage and distance
  always_comb begin
    lo6    = (min_factor == '0) ? CFG_WIDTH'(1) : min_factor;
    lo_ext = EXTW'(lo6);
    hi_a   = (EXTW'(max_factor) > EXTW'(MAX_FACTOR)) ? EXTW'(MAX_FACTOR) : EXTW'(max_factor);
    hi_b   = (hi_a > EXTW'(s_tdata[DW-1:0])) ? EXTW'(s_tdata[DW-1:0]) : hi_a;
    range_ok = (lo_ext <= hi_b);
  end

  // Bump the count, holding it once saturated; an unwritten entry counts as zero
  assign cur_cnt = rd_valid ? rd_data : '0;
  assign inc_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CW'(1);

  // The current entry is the last one when no valid entry lies above it
  assign valid_above = cnt_valid >> idx;
  assign last_here   = ~|valid_above[MAX_FACTOR-1:1];

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (op_t'(s_tuser) == OP_REPORT) begin
            state_next = (cnt_valid == '0) ? ST_RPT_EMPTY : ST_RPT_SCAN;
          end else if (range_ok) begin
            state_next = ST_ADD_RD;
          end
        end
      end
      ST_ADD_RD:  state_next = ST_ADD_DIV;
      ST_ADD_DIV: begin
        if (rem_status.done) state_next = ST_ADD_UPD;
      end
      ST_ADD_UPD: begin
        state_next = (f == hi) ? ST_IDLE : ST_ADD_RD;
      end
      ST_RPT_SCAN: begin
        if (cnt_valid[idx]) state_next = ST_RPT_WAIT;
      end
      ST_RPT_WAIT: state_next = ST_RPT_DIV;
      ST_RPT_DIV: begin
        if (frac_done) state_next = ST_RPT_EMIT;
      end
      ST_RPT_EMIT: begin
        if (out_free) state_next = last_here ? ST_IDLE : ST_RPT_SCAN;
      end
      ST_RPT_EMPTY: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer
  always_comb begin
    s_tready    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx;
    mem_wr_en   = 1'b0;
    rem_start   = 1'b0;
    frac_start  = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_ADD_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = f_addr;
        rem_start   = 1'b1;
      end
      ST_ADD_UPD:   mem_wr_en  = rem_status.zero;
      ST_RPT_SCAN:  mem_rd_en  = cnt_valid[idx];
      ST_RPT_WAIT:  frac_start = 1'b1;
      ST_RPT_EMIT:  out_load   = out_free;
      ST_RPT_EMPTY: out_load   = out_free;
      default: begin
      end
    endcase
  end

  // Count memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      cnt_mem[f_addr] <= inc_cnt;
    end
    if (mem_rd_en) begin
      rd_data <= cnt_mem[mem_rd_addr];
    end
  end

  // Control state, registers, valid flags, largest count, report index and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      min_factor <= MIN_FACTOR_RESET;
      max_factor <= MAX_FACTOR_RESET;
      cnt_valid  <= '0;
      largest    <= '0;
      m_tvalid   <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        case (reg_idx_t'(paddr[2]))
          REG_MIN_FACTOR: min_factor <= pwdata[CFG_WIDTH-1:0];
          REG_MAX_FACTOR: max_factor <= pwdata[CFG_WIDTH-1:0];
          default: begin
          end
        endcase
      end

      // Mark the entry written and follow the largest count
      if (mem_wr_en) begin
        cnt_valid[f_addr] <= 1'b1;
        if (inc_cnt > largest) largest <= inc_cnt;
      end

      // Advance the report index past empty entries; drop each entry once sent
      if (state == ST_IDLE) begin
        idx <= '0;
      end else if ((state == ST_RPT_SCAN) && !cnt_valid[idx]) begin
        idx <= idx + AW'(1);
      end else if ((state == ST_RPT_EMIT) && out_free) begin
        cnt_valid[idx] <= 1'b0;
        if (last_here) begin
          largest <= '0;
        end else begin
          idx <= idx + AW'(1);
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Sequencer payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_acc) begin
      distance <= s_tdata[DW-1:0];
      f        <= FW'(lo6);
      hi       <= hi_b[FW-1:0];
    end else if ((state == ST_ADD_UPD) && (f != hi)) begin
      f <= f + FW'(1);
    end
    if (mem_rd_en) begin
      rd_valid <= cnt_valid[mem_rd_addr];
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_RPT_EMPTY) begin
        out_factor    <= '0;
        out_count     <= '0;
        out_score     <= '0;
        out_valid_res <= 1'b0;
        out_last      <= 1'b1;
      end else begin
        out_factor    <= FACTOR_W'(FW'(idx) + FW'(1));
        out_count     <= COUNT_W'(rd_data);
        out_score     <= frac_quot;
        out_valid_res <= 1'b1;
        out_last      <= last_here;
      end
    end
  end

  assign m_tdata = {{(M_TDATA_W - TDATA_USED_W){1'b0}}, out_score, out_count, out_factor};
  assign m_tuser = out_valid_res;
  assign m_tlast = out_last;

  // Register readback
  always_comb begin
    prdata = '0;
    case (reg_idx_t'(paddr[2]))
      REG_MIN_FACTOR: prdata = APB_DATA_W'(min_factor);
      REG_MAX_FACTOR: prdata = APB_DATA_W'(max_factor);
      default:        prdata = '0;
    endcase
  end

  khist_rem #(
    .DW (DW),
    .VW (FW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (distance),
    .divisor  (f),
    .status   (rem_status)
  );

  khist_frac #(
    .CW (CW)
  ) u_frac (
    .clk   (clk),
    .rst   (rst),
    .start (frac_start),
    .num   (rd_data),
    .den   (largest),
    .done  (frac_done),
    .quot  (frac_quot)
  );

endmodule

FILE: design/khist_checker.sv
// Port-level checks of the factor histogram, bound to the top level.
module khist_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [khist_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import khist_pkg::*;

  logic [SCORE_W-1:0] score;
  assign score = m_tdata[SCORE_LSB +: SCORE_W];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // An empty report result (tuser 0) is all-zero and final
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("empty report result malformed");

  // Score never exceeds one
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> score <= SCORE_ONE)
    else $error("score above one");

  // While a non-final result waits, the report is still running
  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken during a report");

  // Reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind kasiski_factor_histogram_top khist_checker u_khist_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
